// ----- rtl/core/pfb_bw_pkg.sv -----
// ----------------------------------------------------------------------------
// pfb_bw_pkg
// Shared types, register codes and constants of the barrier weight core.
// ----------------------------------------------------------------------------
package pfb_bw_pkg;

  // payload words
  typedef logic signed [31:0] data_t;

  // register map, word index of each register
  typedef enum logic [1:0] {
    REG_ALPHA    = 2'd0,
    REG_SIGMA    = 2'd1,
    REG_ZERO_TOL = 2'd2
  } reg_idx_t;

  // register reset values
  localparam logic [16:0] ALPHA_RST    = 17'd62259;
  localparam logic [30:0] SIGMA_RST    = 31'd65536;
  localparam logic [16:0] ZERO_TOL_RST = 17'd1;

  // saturation limits
  localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] I32_MIN = 32'h8000_0000;

  // front-end sideband: shifted dual, multiplier and saturation flag
  typedef struct packed {
    logic signed [31:0] ys;
    logic signed [31:0] v;
    logic               flag;
  } fb_side_t;

  // back-end sideband for the weight divider
  typedef struct packed {
    logic signed [31:0] gamma;
    logic signed [31:0] mu;
    logic               flag;
    logic               neg;
    logic               ovf;
  } wt_side_t;

  // 2^frac / sqrt(2) rounded to nearest, evaluated at elaboration
  function automatic logic [31:0] inv_sqrt2_fx(input int frac);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    n   = 64'd1 << (2 * frac + 1);
    res = '0;
    bv  = 64'd1 << 62;
    while (bv > n) bv = bv >> 2;
    while (bv != 0) begin
      if (n >= res + bv) begin
        n   = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return 32'((res + 64'd1) >> 1);
  endfunction

endpackage

// ----- rtl/core/pfb_bw_if.sv -----
// ----------------------------------------------------------------------------
// pfb_bw_if
// Item channels of the barrier weight core: constraint items in, results out.
// ----------------------------------------------------------------------------
interface pfb_bw_in_if;
  logic                valid;
  logic                ready;
  pfb_bw_pkg::data_t   dual_value;
  pfb_bw_pkg::data_t   slack_value;
  pfb_bw_pkg::data_t   reference_value;

  modport source (output valid, dual_value, slack_value, reference_value, input ready);
  modport sink   (input valid, dual_value, slack_value, reference_value, output ready);
endinterface

interface pfb_bw_out_if;
  logic                valid;
  logic                ready;
  pfb_bw_pkg::data_t   gamma_out;
  pfb_bw_pkg::data_t   mu_out;
  pfb_bw_pkg::data_t   weight_out;
  logic                saturated;

  modport source (output valid, gamma_out, mu_out, weight_out, saturated, input ready);
  modport sink   (input valid, gamma_out, mu_out, weight_out, saturated, output ready);
endinterface

// ----- rtl/core/pfb_barrier_weight_core.sv -----
// ----------------------------------------------------------------------------
// pfb_barrier_weight_core
// Penalized Fischer-Burmeister gradient and barrier weight, one constraint
// per item, fully pipelined in fixed point.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-----------------------------------------
//  req     | in  | valid / ready    | dual_value, slack_value, reference_value
//  rsp     | out | valid / ready    | gamma_out, mu_out, weight_out, saturated
//  apb     | in  | psel / penable   | paddr, pwdata, prdata (pready tied high)
//
//  one item per cycle while the output is taken; Q16.16 at FRAC_BITS = 16.
//  the pipeline holds the 32-stage square root and the two restoring dividers
//  (FRAC_BITS + 1 and 32 stages). reset clears the valid bits and loads the
//  register defaults. a full output register that is not taken holds the whole pipeline.
// ----------------------------------------------------------------------------
module pfb_barrier_weight_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  pfb_bw_in_if.sink   req,
  pfb_bw_out_if.source rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned ONE_VAL = 1 << FRAC_BITS;
  localparam logic [31:0] DCONST  = pfb_bw_pkg::inv_sqrt2_fx(FRAC_BITS);
  localparam int QW   = FRAC_BITS + 1;               // quotient bits of ys/r
  localparam int RW   = 33 + FRAC_BITS;              // remainder of ys/r
  localparam int EW   = FRAC_BITS + 3;               // 1 - q
  localparam int AW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;  // 1 - alpha
  localparam int P0W  = EW + 18;
  localparam int P2W  = AW + 32;
  localparam int GW   = P2W + 1;
  localparam int NW   = 32 + FRAC_BITS;              // weight numerator
  localparam int NST  = 77 + QW;

  // configuration registers
  logic [16:0] alpha;
  logic [30:0] sigma;
  logic [16:0] zero_tol;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha    <= pfb_bw_pkg::ALPHA_RST;
      sigma    <= pfb_bw_pkg::SIGMA_RST;
      zero_tol <= pfb_bw_pkg::ZERO_TOL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (pfb_bw_pkg::reg_idx_t'(paddr[3:2]))
        pfb_bw_pkg::REG_ALPHA:    alpha    <= pwdata[16:0];
        pfb_bw_pkg::REG_SIGMA:    sigma    <= pwdata[30:0];
        pfb_bw_pkg::REG_ZERO_TOL: zero_tol <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    unique case (pfb_bw_pkg::reg_idx_t'(paddr[3:2]))
      pfb_bw_pkg::REG_ALPHA:    prdata = 32'(alpha);
      pfb_bw_pkg::REG_SIGMA:    prdata = 32'(sigma);
      pfb_bw_pkg::REG_ZERO_TOL: prdata = 32'(zero_tol);
      default:                  prdata = '0;
    endcase
  end

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  // pipeline advance and valid bits
  logic           adv;
  logic [NST-1:0] vld;

  assign adv       = !vld[NST-1] || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], req.valid};
    end
  end

  // stage 1: capture, v - vbar
  logic signed [31:0] y1, v1;
  logic signed [32:0] d1;
  always_ff @(posedge clk) begin
    if (adv) begin
      y1 <= req.dual_value;
      v1 <= req.slack_value;
      d1 <= $signed({req.slack_value[31], req.slack_value})
          - $signed({req.reference_value[31], req.reference_value});
    end
  end

  // stage 2: sigma * (v - vbar)
  logic signed [31:0] y2, v2;
  logic signed [64:0] prod1;
  always_ff @(posedge clk) begin
    if (adv) begin
      y2    <= y1;
      v2    <= v1;
      prod1 <= $signed({1'b0, sigma}) * d1;
    end
  end

  // stage 3: ys = y + shifted product, saturated
  logic signed [65:0] ys_sum;
  logic               ys_fits;
  pfb_bw_pkg::fb_side_t side3;
  assign ys_sum  = 66'(y2) + 66'(prod1 >>> FRAC_BITS);
  assign ys_fits = (ys_sum[65:31] == {35{ys_sum[31]}});
  always_ff @(posedge clk) begin
    if (adv) begin
      side3.ys   <= ys_fits ? ys_sum[31:0]
                  : (ys_sum[65] ? pfb_bw_pkg::I32_MIN : pfb_bw_pkg::I32_MAX);
      side3.v    <= v2;
      side3.flag <= !ys_fits;
    end
  end

  // stage 4: squares of the magnitudes
  logic [63:0] my2, mv2;
  pfb_bw_pkg::fb_side_t side4;
  logic [31:0] my3, mv3;
  assign my3 = mag32(side3.ys);
  assign mv3 = mag32(side3.v);
  always_ff @(posedge clk) begin
    if (adv) begin
      my2   <= my3 * my3;
      mv2   <= mv3 * mv3;
      side4 <= side3;
    end
  end

  // stage 5 and square root: one result bit per stage
  logic [63:0]          sq_rem  [0:32];
  logic [31:0]          sq_root [0:32];
  pfb_bw_pkg::fb_side_t sq_side [0:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0]  <= my2 + mv2;
      sq_root[0] <= '0;
      sq_side[0] <= side4;
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam int K = 31 - j;
    logic [63:0] trial;
    assign trial = (64'(sq_root[j]) << (K + 1)) | (64'd1 << (2 * K));
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side[j+1] <= sq_side[j];
        if (sq_rem[j] >= trial) begin
          sq_rem[j+1]  <= sq_rem[j] - trial;
          sq_root[j+1] <= sq_root[j] | (32'd1 << K);
        end else begin
          sq_rem[j+1]  <= sq_rem[j];
          sq_root[j+1] <= sq_root[j];
        end
      end
    end
  end

  // divider setup: |ys|/r and |v|/r, small-norm test
  logic [RW-1:0]        dv_rema [0:QW];
  logic [RW-1:0]        dv_remb [0:QW];
  logic [QW-1:0]        dv_qa   [0:QW];
  logic [QW-1:0]        dv_qb   [0:QW];
  logic [31:0]          dv_r    [0:QW];
  logic                 dv_small[0:QW];
  pfb_bw_pkg::fb_side_t dv_side [0:QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rema[0]  <= RW'({mag32(sq_side[32].ys), {FRAC_BITS{1'b0}}});
      dv_remb[0]  <= RW'({mag32(sq_side[32].v), {FRAC_BITS{1'b0}}});
      dv_qa[0]    <= '0;
      dv_qb[0]    <= '0;
      dv_r[0]     <= sq_root[32];
      dv_small[0] <= (sq_root[32] == '0) || (sq_root[32] < 32'(zero_tol));
      dv_side[0]  <= sq_side[32];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_qdiv
    localparam int K = FRAC_BITS - j;
    logic [RW-1:0] sub;
    assign sub = RW'(dv_r[j]) << K;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[j+1]     <= dv_r[j];
        dv_small[j+1] <= dv_small[j];
        dv_side[j+1]  <= dv_side[j];
        if (dv_rema[j] >= sub) begin
          dv_rema[j+1] <= dv_rema[j] - sub;
          dv_qa[j+1]   <= dv_qa[j] | (QW'(1) << K);
        end else begin
          dv_rema[j+1] <= dv_rema[j];
          dv_qa[j+1]   <= dv_qa[j];
        end
        if (dv_remb[j] >= sub) begin
          dv_remb[j+1] <= dv_remb[j] - sub;
          dv_qb[j+1]   <= dv_qb[j] | (QW'(1) << K);
        end else begin
          dv_remb[j+1] <= dv_remb[j];
          dv_qb[j+1]   <= dv_qb[j];
        end
      end
    end
  end

  // g1 stage: signed quotients, 1 - q terms, case select
  logic signed [QW:0]   qa, qb;
  logic signed [EW-1:0] e0, e1;
  logic                 pos1;
  pfb_bw_pkg::fb_side_t side_g1;
  logic signed [AW-1:0] oneal;

  assign qa = dv_side[QW].ys[31] ? -$signed({1'b0, dv_qa[QW]}) : $signed({1'b0, dv_qa[QW]});
  assign qb = dv_side[QW].v[31]  ? -$signed({1'b0, dv_qb[QW]}) : $signed({1'b0, dv_qb[QW]});
  assign oneal = $signed(AW'(ONE_VAL)) - $signed(AW'(alpha));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dv_small[QW]) begin
        e0 <= $signed(EW'(ONE_VAL - DCONST));
        e1 <= $signed(EW'(ONE_VAL - DCONST));
      end else begin
        e0 <= $signed(EW'(ONE_VAL)) - EW'(qa);
        e1 <= $signed(EW'(ONE_VAL)) - EW'(qb);
      end
      pos1 <= !dv_small[QW]
           && !dv_side[QW].ys[31] && (dv_side[QW].ys != '0)
           && !dv_side[QW].v[31]  && (dv_side[QW].v != '0);
      side_g1 <= dv_side[QW];
    end
  end

  // g2 stage: alpha and (1 - alpha) products
  logic signed [P0W-1:0] p0, p1;
  logic signed [P2W-1:0] p2, p3;
  logic                  pos2;
  logic                  flag2;
  always_ff @(posedge clk) begin
    if (adv) begin
      p0    <= $signed({1'b0, alpha}) * e0;
      p1    <= $signed({1'b0, alpha}) * e1;
      p2    <= oneal * side_g1.v;
      p3    <= oneal * side_g1.ys;
      pos2  <= pos1;
      flag2 <= side_g1.flag;
    end
  end

  // g3 stage: gradient sums, saturate gamma and g1
  logic signed [GW-1:0] g0s, g1s_sum;
  logic                 g0_fits, g1_fits;
  logic signed [31:0]   gamma3, g1_3;
  logic                 flag3;

  assign g0s     = GW'(p0 >>> FRAC_BITS) + (pos2 ? GW'(p2 >>> FRAC_BITS) : GW'(0));
  assign g1s_sum = GW'(p1 >>> FRAC_BITS) + (pos2 ? GW'(p3 >>> FRAC_BITS) : GW'(0));
  assign g0_fits = (g0s[GW-1:31] == {(GW-31){g0s[31]}});
  assign g1_fits = (g1s_sum[GW-1:31] == {(GW-31){g1s_sum[31]}});

  always_ff @(posedge clk) begin
    if (adv) begin
      gamma3 <= g0_fits ? g0s[31:0]
              : (g0s[GW-1] ? pfb_bw_pkg::I32_MIN : pfb_bw_pkg::I32_MAX);
      g1_3   <= g1_fits ? g1s_sum[31:0]
              : (g1s_sum[GW-1] ? pfb_bw_pkg::I32_MIN : pfb_bw_pkg::I32_MAX);
      flag3  <= flag2 || !g0_fits || !g1_fits;
    end
  end

  // g4 stage: sigma * gamma
  logic signed [63:0] prod2;
  logic signed [31:0] gamma4, g1_4;
  logic               flag4;
  always_ff @(posedge clk) begin
    if (adv) begin
      prod2  <= $signed({1'b0, sigma}) * gamma3;
      gamma4 <= gamma3;
      g1_4   <= g1_3;
      flag4  <= flag3;
    end
  end

  // g5 stage: mu, saturated
  logic signed [64:0] mu_sum;
  logic               mu_fits;
  logic signed [31:0] gamma5, mu5;
  logic               flag5;
  assign mu_sum  = 65'(g1_4) + 65'(prod2 >>> FRAC_BITS);
  assign mu_fits = (mu_sum[64:31] == {34{mu_sum[31]}});
  always_ff @(posedge clk) begin
    if (adv) begin
      gamma5 <= gamma4;
      mu5    <= mu_fits ? mu_sum[31:0]
              : (mu_sum[64] ? pfb_bw_pkg::I32_MIN : pfb_bw_pkg::I32_MAX);
      flag5  <= flag4 || !mu_fits;
    end
  end

  // weight divider setup: overflow when the quotient needs more than 32 bits
  logic [NW-1:0]        wd_rem  [0:32];
  logic [31:0]          wd_d    [0:32];
  logic [31:0]          wd_q    [0:32];
  pfb_bw_pkg::wt_side_t wd_side [0:32];
  logic [31:0]          gm5, dm5;

  assign gm5 = mag32(gamma5);
  assign dm5 = mag32(mu5);

  always_ff @(posedge clk) begin
    if (adv) begin
      wd_rem[0]        <= {gm5, {FRAC_BITS{1'b0}}};
      wd_d[0]          <= dm5;
      wd_q[0]          <= '0;
      wd_side[0].gamma <= gamma5;
      wd_side[0].mu    <= mu5;
      wd_side[0].flag  <= flag5;
      wd_side[0].neg   <= gamma5[31] ^ mu5[31];
      wd_side[0].ovf   <= 65'({gm5, {FRAC_BITS{1'b0}}}) >= {1'b0, dm5, 32'd0};
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_wdiv
    localparam int K = 31 - j;
    logic [63:0] sub;
    assign sub = 64'(wd_d[j]) << K;
    always_ff @(posedge clk) begin
      if (adv) begin
        wd_d[j+1]    <= wd_d[j];
        wd_side[j+1] <= wd_side[j];
        if (64'(wd_rem[j]) >= sub) begin
          wd_rem[j+1] <= wd_rem[j] - NW'(sub);
          wd_q[j+1]   <= wd_q[j] | (32'd1 << K);
        end else begin
          wd_rem[j+1] <= wd_rem[j];
          wd_q[j+1]   <= wd_q[j];
        end
      end
    end
  end

  // sign and saturation of the weight
  logic [31:0] weight_c;
  logic        wsat_c;
  always_comb begin
    wsat_c   = 1'b0;
    weight_c = wd_q[32];
    if (wd_side[32].ovf) begin
      wsat_c   = 1'b1;
      weight_c = wd_side[32].neg ? pfb_bw_pkg::I32_MIN : pfb_bw_pkg::I32_MAX;
    end else if (wd_side[32].neg) begin
      if (wd_q[32] > pfb_bw_pkg::I32_MIN) begin
        wsat_c   = 1'b1;
        weight_c = pfb_bw_pkg::I32_MIN;
      end else begin
        weight_c = 32'(-wd_q[32]);
      end
    end else if (wd_q[32][31]) begin
      wsat_c   = 1'b1;
      weight_c = pfb_bw_pkg::I32_MAX;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.gamma_out  <= wd_side[32].gamma;
      rsp.mu_out     <= wd_side[32].mu;
      rsp.weight_out <= weight_c;
      rsp.saturated  <= wd_side[32].flag || wsat_c;
    end
  end

endmodule

// ----- rtl/core/pfb_bw_checker.sv -----
// ----------------------------------------------------------------------------
// pfb_bw_checker
// Port-level checks of the barrier weight core, bound to the top level.
// ----------------------------------------------------------------------------
module pfb_bw_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input pfb_bw_pkg::data_t gamma_out,
  input pfb_bw_pkg::data_t mu_out,
  input pfb_bw_pkg::data_t weight_out,
  input logic              saturated
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // zero mu always raises the flag
  a_zero_mu_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mu_out == 0) |-> saturated)
    else $error("zero mu without saturated flag");

  // zero mu with non-negative gamma gives the positive limit
  a_zero_mu_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mu_out == 0) && !gamma_out[31] |-> (weight_out == 32'sh7FFF_FFFF))
    else $error("zero mu weight not at positive limit");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight_out))
    else $error("stalled result changed");

endmodule

bind pfb_barrier_weight_core pfb_bw_checker u_pfb_bw_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .gamma_out  (rsp.gamma_out),
  .mu_out     (rsp.mu_out),
  .weight_out (rsp.weight_out),
  .saturated  (rsp.saturated)
);
